FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define AAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/aar_pkg.sv
// Types and constants of the axis-angle rotation matrix block.
package aar_pkg;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned ANGLE_BITS = 16;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Taylor series divisors, applied in this order by the Horner steps
  localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

  // Q30 to output scaling
  localparam int unsigned OUT_SH  = 30 - FRAC_BITS;
  localparam int unsigned OUT_RND = (OUT_SH > 0) ? (1 << (OUT_SH - 1)) : 0;
  localparam logic signed [15:0] ONE_OUT =
    (FRAC_BITS >= 15) ? 16'sh7FFF : 16'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
    logic        [15:0] angle;
  } unit_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
    logic signed [31:0] s;
    logic signed [31:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m01;
    logic signed [15:0] m11;
    logic signed [15:0] m21;
    logic signed [15:0] m02;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
    logic               zero_axis;
  } out_word_t;

endpackage

FILE: hw/rtl/aar_if.sv
// Valid/ready stream interfaces for the input and result words.
interface aar_in_if;
  import aar_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aar_out_if;
  import aar_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/aar_norm.sv
// Axis normalization: squares, bit-serial square root and restoring division.
module aar_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aar_pkg::in_word_t data_i,
  output logic              valid_o,
  output aar_pkg::unit_t    data_o
);
  import aar_pkg::*;

  localparam int unsigned NSQ  = 32;
  localparam int unsigned NDIV = 31;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
    logic [15:0]      angle;
  } side_t;

  logic signed [15:0] comp_in [3];
  logic [2:0][15:0]   mag_in;

  assign comp_in[0] = data_i.axis_x;
  assign comp_in[1] = data_i.axis_y;
  assign comp_in[2] = data_i.axis_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = comp_in[k][15] ? 16'(-comp_in[k]) : 16'(comp_in[k]);
    end
  end

  // squares
  logic             sq_v_q;
  side_t            sq_side_q;
  logic [2:0][31:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en_i) begin
      sq_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_side_q.mag   <= mag_in;
      sq_side_q.neg   <= {comp_in[2][15], comp_in[1][15], comp_in[0][15]};
      sq_side_q.zero  <= (mag_in == '0);
      sq_side_q.angle <= data_i.angle;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= 32'(mag_in[k]) * 32'(mag_in[k]);
      end
    end
  end

  // square root of l2 << 32, one result bit a stage
  logic        rt_v_q    [NSQ+1];
  side_t       rt_side_q [NSQ+1];
  logic [31:0] rt_l2_q   [NSQ+1];
  logic [34:0] rt_rem_q  [NSQ+1];
  logic [31:0] rt_root_q [NSQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q[0] <= 1'b0;
    end else if (en_i) begin
      rt_v_q[0] <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_side_q[0] <= sq_side_q;
      rt_l2_q[0]   <= sq_q[0] + sq_q[1] + sq_q[2];
      rt_rem_q[0]  <= '0;
      rt_root_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    logic [1:0]  pair;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    if (i < NSQ / 2) begin : g_hi
      assign pair = rt_l2_q[i][31-2*i -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign rem_sh = {rt_rem_q[i][32:0], pair};
    assign trial  = {1'b0, rt_root_q[i], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        rt_v_q[i+1] <= rt_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_side_q[i+1] <= rt_side_q[i];
        rt_l2_q[i+1]   <= rt_l2_q[i];
        if (rem_sh >= trial) begin
          rt_rem_q[i+1]  <= rem_sh - trial;
          rt_root_q[i+1] <= {rt_root_q[i][30:0], 1'b1};
        end else begin
          rt_rem_q[i+1]  <= rem_sh;
          rt_root_q[i+1] <= {rt_root_q[i][30:0], 1'b0};
        end
      end
    end
  end

  // |a| << 46 / len, one quotient bit a stage, three lanes
  logic             dv_v_q    [NDIV+1];
  side_t            dv_side_q [NDIV+1];
  logic [31:0]      dv_den_q  [NDIV+1];
  logic [2:0][31:0] dv_rem_q  [NDIV+1];
  logic [2:0][30:0] dv_quo_q  [NDIV+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= rt_v_q[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_side_q[0] <= rt_side_q[NSQ];
      dv_den_q[0]  <= rt_root_q[NSQ];
      dv_quo_q[0]  <= '0;
      for (int k = 0; k < 3; k++) begin
        dv_rem_q[0][k] <= {1'b0, rt_side_q[NSQ].mag[k], 15'b0};
      end
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [2:0][32:0] rem_sh;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_sh[k] = {dv_rem_q[j][k], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_side_q[j+1] <= dv_side_q[j];
        dv_den_q[j+1]  <= dv_den_q[j];
        for (int k = 0; k < 3; k++) begin
          if (rem_sh[k] >= {1'b0, dv_den_q[j]}) begin
            dv_rem_q[j+1][k] <= 32'(rem_sh[k] - {1'b0, dv_den_q[j]});
            dv_quo_q[j+1][k] <= {dv_quo_q[j][k][29:0], 1'b1};
          end else begin
            dv_rem_q[j+1][k] <= 32'(rem_sh[k]);
            dv_quo_q[j+1][k] <= {dv_quo_q[j][k][29:0], 1'b0};
          end
        end
      end
    end
  end

  // clamp to one and restore sign
  logic [2:0][30:0]   quo_cl;
  logic signed [31:0] unit_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo_cl[k] = (dv_quo_q[NDIV][k] > Q30_ONE) ? Q30_ONE : dv_quo_q[NDIV][k];
      unit_c[k] = dv_side_q[NDIV].neg[k] ? -$signed({1'b0, quo_cl[k]})
                                          :  $signed({1'b0, quo_cl[k]});
    end
  end

  logic  out_v_q;
  unit_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_v_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.x     <= unit_c[0];
      out_q.y     <= unit_c[1];
      out_q.z     <= unit_c[2];
      out_q.zero  <= dv_side_q[NDIV].zero;
      out_q.angle <= dv_side_q[NDIV].angle;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

FILE: hw/rtl/aar_sincos.sv
// Sine and cosine in Q30: octant fold, Horner-form series, octant unfold.
module aar_sincos (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  aar_pkg::unit_t data_i,
  output logic           valid_o,
  output aar_pkg::trig_t data_o
);
  import aar_pkg::*;

  localparam int unsigned NSTEP = 6;
  localparam logic [31:0] ANGLE_MASK =
    (ANGLE_BITS < 32) ? 32'((64'd1 << ANGLE_BITS) - 64'd1) : 32'hFFFF_FFFF;

  typedef struct packed {
    unit_t       u;
    logic [2:0]  oct;
    logic [29:0] phi;
    logic [29:0] p2;
  } hc_t;

  // fold into the first octant
  logic [31:0] turn;
  logic [28:0] rem29;
  logic [29:0] fold;

  assign turn  = ({16'b0, data_i.angle} & ANGLE_MASK) << (32 - ANGLE_BITS);
  assign rem29 = turn[28:0];
  assign fold  = turn[29] ? (30'h2000_0000 - {1'b0, rem29}) : {1'b0, rem29};

  logic        f_v_q;
  unit_t       f_u_q;
  logic [2:0]  f_oct_q;
  logic [29:0] f_r_q;

  logic        ph_v_q;
  hc_t         ph_q;
  logic [63:0] phi_full;

  logic        sq_v_q;
  hc_t         sq_q;
  logic [63:0] p2_full;

  assign phi_full = 64'(f_r_q) * TWO_PI_Q30 + (64'd1 << 31);
  assign p2_full  = 64'(ph_q.phi) * 64'(ph_q.phi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q  <= 1'b0;
      ph_v_q <= 1'b0;
      sq_v_q <= 1'b0;
    end else if (en_i) begin
      f_v_q  <= valid_i;
      ph_v_q <= f_v_q;
      sq_v_q <= ph_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_u_q   <= data_i;
      f_oct_q <= turn[31:29];
      f_r_q   <= fold;
      ph_q.u   <= f_u_q;
      ph_q.oct <= f_oct_q;
      ph_q.phi <= phi_full[61:32];
      ph_q.p2  <= '0;
      sq_q.u   <= ph_q.u;
      sq_q.oct <= ph_q.oct;
      sq_q.phi <= ph_q.phi;
      sq_q.p2  <= p2_full[59:30];
    end
  end

  // Horner steps: multiply stage, then reciprocal multiply and subtract
  logic        hb_v_q  [NSTEP+1];
  hc_t         hb_hc_q [NSTEP+1];
  logic [30:0] hb_st_q [NSTEP+1];
  logic [30:0] hb_ct_q [NSTEP+1];

  logic        pa_v_q  [NSTEP];
  hc_t         pa_hc_q [NSTEP];
  logic [30:0] pa_st_q [NSTEP];
  logic [29:0] pa_sp_q [NSTEP];
  logic [29:0] pa_cp_q [NSTEP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_v_q[0] <= 1'b0;
    end else if (en_i) begin
      hb_v_q[0] <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hb_hc_q[0] <= sq_q;
      hb_st_q[0] <= Q30_ONE;
      hb_ct_q[0] <= Q30_ONE;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int unsigned CD = COS_DIV[j];
    localparam int unsigned CK = 30 + $clog2(CD);
    localparam logic [31:0] CM = 32'(((64'd1 << CK) + 64'(CD) - 64'd1) / 64'(CD));

    logic [63:0] sprod;
    logic [63:0] cprod;
    logic [63:0] cquo;
    logic [30:0] st_nxt;

    assign sprod = 64'(hb_hc_q[j].p2) * 64'(hb_st_q[j]);
    assign cprod = 64'(hb_hc_q[j].p2) * 64'(hb_ct_q[j]);
    assign cquo  = (64'(pa_cp_q[j]) * 64'(CM)) >> CK;

    if (j == 0) begin : g_sin_wait
      assign st_nxt = pa_st_q[j];
    end else begin : g_sin_step
      localparam int unsigned SD = SIN_DIV[j-1];
      localparam int unsigned SK = 30 + $clog2(SD);
      localparam logic [31:0] SM =
        32'(((64'd1 << SK) + 64'(SD) - 64'd1) / 64'(SD));
      logic [63:0] squo;
      assign squo   = (64'(pa_sp_q[j]) * 64'(SM)) >> SK;
      assign st_nxt = Q30_ONE - 31'(squo);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pa_v_q[j]   <= 1'b0;
        hb_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        pa_v_q[j]   <= hb_v_q[j];
        hb_v_q[j+1] <= pa_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_hc_q[j]   <= hb_hc_q[j];
        pa_st_q[j]   <= hb_st_q[j];
        pa_sp_q[j]   <= sprod[59:30];
        pa_cp_q[j]   <= cprod[59:30];
        hb_hc_q[j+1] <= pa_hc_q[j];
        hb_st_q[j+1] <= st_nxt;
        hb_ct_q[j+1] <= Q30_ONE - 31'(cquo);
      end
    end
  end

  // sin = phi * series, then unfold by octant
  logic        e1_v_q;
  hc_t         e1_hc_q;
  logic [29:0] e1_sp_q;
  logic [30:0] e1_cp_q;
  logic [63:0] sp_full;

  assign sp_full = 64'(hb_hc_q[NSTEP].phi) * 64'(hb_st_q[NSTEP]);

  logic signed [31:0] sp_s;
  logic signed [31:0] cp_s;
  logic signed [31:0] s_oct;
  logic signed [31:0] c_oct;

  assign sp_s = $signed({2'b00, e1_sp_q});
  assign cp_s = $signed({1'b0, e1_cp_q});

  always_comb begin
    unique case (e1_hc_q.oct)
      3'd0: begin s_oct =  sp_s; c_oct =  cp_s; end
      3'd1: begin s_oct =  cp_s; c_oct =  sp_s; end
      3'd2: begin s_oct =  cp_s; c_oct = -sp_s; end
      3'd3: begin s_oct =  sp_s; c_oct = -cp_s; end
      3'd4: begin s_oct = -sp_s; c_oct = -cp_s; end
      3'd5: begin s_oct = -cp_s; c_oct = -sp_s; end
      3'd6: begin s_oct = -cp_s; c_oct =  sp_s; end
      3'd7: begin s_oct = -sp_s; c_oct =  cp_s; end
      default: begin s_oct = sp_s; c_oct = cp_s; end
    endcase
  end

  logic  e2_v_q;
  trig_t e2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
    end else if (en_i) begin
      e1_v_q <= hb_v_q[NSTEP];
      e2_v_q <= e1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_hc_q   <= hb_hc_q[NSTEP];
      e1_sp_q   <= sp_full[59:30];
      e1_cp_q   <= hb_ct_q[NSTEP];
      e2_q.x    <= e1_hc_q.u.x;
      e2_q.y    <= e1_hc_q.u.y;
      e2_q.z    <= e1_hc_q.u.z;
      e2_q.zero <= e1_hc_q.u.zero;
      e2_q.s    <= s_oct;
      e2_q.c    <= c_oct;
    end
  end

  assign valid_o = e2_v_q;
  assign data_o  = e2_q;

endmodule

FILE: hw/rtl/aar_rodrigues.sv
// Rodrigues matrix: rounded Q30 products, sums and output scaling.
module aar_rodrigues (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  aar_pkg::trig_t     data_i,
  output logic               valid_o,
  output aar_pkg::out_word_t data_o
);
  import aar_pkg::*;

  // product slots
  localparam int unsigned P_XX = 0;
  localparam int unsigned P_YY = 1;
  localparam int unsigned P_ZZ = 2;
  localparam int unsigned P_XY = 3;
  localparam int unsigned P_XZ = 4;
  localparam int unsigned P_YZ = 5;
  localparam int unsigned P_SX = 6;
  localparam int unsigned P_SY = 7;
  localparam int unsigned P_SZ = 8;
  localparam int unsigned NP   = 9;
  localparam int unsigned NT   = 6;

  function automatic logic signed [33:0] qround(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + (64'd1 << 29)) >> 30;
    return p[63] ? -$signed(34'(r)) : $signed(34'(r));
  endfunction

  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic [35:0] mag;
    logic [35:0] m;
    mag = v[35] ? 36'(-v) : 36'(v);
    m   = (mag + 36'(OUT_RND)) >> OUT_SH;
    if (v[35]) begin
      return (m > 36'd32768) ? 16'h8000 : 16'(-m);
    end
    return (m > 36'd32767) ? 16'h7FFF : 16'(m);
  endfunction

  // stage 1: raw products of the axis and of sin with the axis
  logic               r1_v_q;
  logic signed [63:0] r1_p_q [NP];
  logic signed [33:0] r1_t_q;
  logic signed [31:0] r1_c_q;
  logic               r1_z_q;

  // stage 2: rounded
  logic               r2_v_q;
  logic signed [33:0] r2_q_q [NP];
  logic signed [33:0] r2_t_q;
  logic signed [31:0] r2_c_q;
  logic               r2_z_q;

  // stage 3: times t
  logic               r3_v_q;
  logic signed [63:0] r3_p_q [NT];
  logic signed [33:0] r3_s_q [3];
  logic signed [31:0] r3_c_q;
  logic               r3_z_q;

  // stage 4: rounded
  logic               r4_v_q;
  logic signed [33:0] r4_q_q [NT];
  logic signed [33:0] r4_s_q [3];
  logic signed [31:0] r4_c_q;
  logic               r4_z_q;

  // stage 5: entries in Q30
  logic               r5_v_q;
  logic signed [35:0] r5_m_q [9];
  logic               r5_z_q;

  logic               r6_v_q;
  out_word_t          r6_q;

  logic signed [35:0] m_sum [9];
  logic signed [35:0] c36;

  assign c36 = 36'(r4_c_q);

  always_comb begin
    m_sum[0] = 36'(r4_q_q[P_XX]) + c36;
    m_sum[1] = 36'(r4_q_q[P_XY]) - 36'(r4_s_q[2]);
    m_sum[2] = 36'(r4_q_q[P_XZ]) + 36'(r4_s_q[1]);
    m_sum[3] = 36'(r4_q_q[P_XY]) + 36'(r4_s_q[2]);
    m_sum[4] = 36'(r4_q_q[P_YY]) + c36;
    m_sum[5] = 36'(r4_q_q[P_YZ]) - 36'(r4_s_q[0]);
    m_sum[6] = 36'(r4_q_q[P_XZ]) - 36'(r4_s_q[1]);
    m_sum[7] = 36'(r4_q_q[P_YZ]) + 36'(r4_s_q[0]);
    m_sum[8] = 36'(r4_q_q[P_ZZ]) + c36;
    if (r4_z_q) begin
      for (int k = 0; k < 9; k++) begin
        m_sum[k] = ((k % 4) == 0) ? 36'(Q30_ONE) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
      r5_v_q <= 1'b0;
      r6_v_q <= 1'b0;
    end else if (en_i) begin
      r1_v_q <= valid_i;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      r5_v_q <= r4_v_q;
      r6_v_q <= r5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_p_q[P_XX] <= 64'(data_i.x) * 64'(data_i.x);
      r1_p_q[P_YY] <= 64'(data_i.y) * 64'(data_i.y);
      r1_p_q[P_ZZ] <= 64'(data_i.z) * 64'(data_i.z);
      r1_p_q[P_XY] <= 64'(data_i.x) * 64'(data_i.y);
      r1_p_q[P_XZ] <= 64'(data_i.x) * 64'(data_i.z);
      r1_p_q[P_YZ] <= 64'(data_i.y) * 64'(data_i.z);
      r1_p_q[P_SX] <= 64'(data_i.s) * 64'(data_i.x);
      r1_p_q[P_SY] <= 64'(data_i.s) * 64'(data_i.y);
      r1_p_q[P_SZ] <= 64'(data_i.s) * 64'(data_i.z);
      r1_t_q       <= $signed(34'(Q30_ONE)) - 34'(data_i.c);
      r1_c_q       <= data_i.c;
      r1_z_q       <= data_i.zero;

      for (int k = 0; k < NP; k++) begin
        r2_q_q[k] <= qround(r1_p_q[k]);
      end
      r2_t_q <= r1_t_q;
      r2_c_q <= r1_c_q;
      r2_z_q <= r1_z_q;

      for (int k = 0; k < NT; k++) begin
        r3_p_q[k] <= 64'(r2_t_q) * 64'(r2_q_q[k]);
      end
      r3_s_q[0] <= r2_q_q[P_SX];
      r3_s_q[1] <= r2_q_q[P_SY];
      r3_s_q[2] <= r2_q_q[P_SZ];
      r3_c_q    <= r2_c_q;
      r3_z_q    <= r2_z_q;

      for (int k = 0; k < NT; k++) begin
        r4_q_q[k] <= qround(r3_p_q[k]);
      end
      r4_s_q <= r3_s_q;
      r4_c_q <= r3_c_q;
      r4_z_q <= r3_z_q;

      r5_m_q <= m_sum;
      r5_z_q <= r4_z_q;

      r6_q.m00       <= $signed(to_out(r5_m_q[0]));
      r6_q.m10       <= $signed(to_out(r5_m_q[1]));
      r6_q.m20       <= $signed(to_out(r5_m_q[2]));
      r6_q.m01       <= $signed(to_out(r5_m_q[3]));
      r6_q.m11       <= $signed(to_out(r5_m_q[4]));
      r6_q.m21       <= $signed(to_out(r5_m_q[5]));
      r6_q.m02       <= $signed(to_out(r5_m_q[6]));
      r6_q.m12       <= $signed(to_out(r5_m_q[7]));
      r6_q.m22       <= $signed(to_out(r5_m_q[8]));
      r6_q.zero_axis <= r5_z_q;
    end
  end

  assign valid_o = r6_v_q;
  assign data_o  = r6_q;

endmodule

FILE: hw/rtl/axis_angle_rotation_matrix.sv
// Top level: axis-angle to 3x3 rotation matrix pipeline with output skid stage.
//
//   channel | dir | modport | word
//   --------+-----+---------+--------------------------------------------
//   in_i    | in  | sink    | axis_x, axis_y, axis_z, angle
//   out_o   | out | source  | m00..m22 (Q2.14), zero_axis
//
// One word enters per cycle while in_i.ready is high. Most of the pipeline
// depth comes from the 32-stage square root and the 31-stage divider of
// the normalizer.
// All pipeline stages advance together on one enable. A stalled result
// parks in the output register, the next one in the skid register, and
// only a full skid register drops in_i.ready.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers
// are not reset.
module axis_angle_rotation_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  aar_in_if.sink      in_i,
  aar_out_if.source   out_o
);
  import aar_pkg::*;

  `include "assert_macros.svh"

  logic      en;
  logic      skid_v_q;
  out_word_t skid_q;
  logic      out_v_q;
  out_word_t out_q;
  logic      take;

  // advance the whole pipeline whenever the skid register is free
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  logic      nrm_v;
  unit_t     nrm_w;
  logic      trg_v;
  trig_t     trg_w;
  logic      mat_v;
  out_word_t mat_w;

  aar_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (nrm_v),
    .data_o  (nrm_w)
  );

  aar_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nrm_v),
    .data_i  (nrm_w),
    .valid_o (trg_v),
    .data_o  (trg_w)
  );

  aar_rodrigues u_rodrigues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trg_v),
    .data_i  (trg_w),
    .valid_o (mat_v),
    .data_o  (mat_w)
  );

  // output register plus skid: a word leaving the pipeline goes straight out
  // if the output slot is free or being drained, else it waits in the skid
  assign take = out_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (mat_v) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (mat_v) begin
      if (!out_v_q || take) begin
        out_q <= mat_w;
      end else begin
        skid_q <= mat_w;
      end
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // the skid register only fills behind a waiting output word
  `AAR_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid full with empty output")
  // a drained output frees the skid in the next cycle
  `AAR_ASSERT(a_skid_drains, (skid_v_q && out_o.ready) |=> !skid_v_q, "skid not drained")
  // a zero axis gives the identity (diagonal, m10 and m01 checked)
  `AAR_ASSERT(a_zero_identity, (out_v_q && out_q.zero_axis) |-> (out_q.m00 == ONE_OUT && out_q.m11 == ONE_OUT && out_q.m22 == ONE_OUT && out_q.m10 == 16'sd0 && out_q.m01 == 16'sd0), "zero axis not identity")
  // no word is shown while reset holds
  `AAR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_o.valid, "valid during reset")

endmodule

FILE: tb/sv/axis_angle_rotation_matrix_tb.sv
// Self-checking testbench of the axis-angle to rotation matrix block.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_tb;
  import aar_pkg::*;

  // Constants of the matrix arithmetic. All internal values are Q30.
  localparam longint unsigned UNIT_Q30  = 64'd1 << 30;
  localparam longint unsigned TURN_STEP = 64'd6746518852;  // 2*pi in Q30
  localparam int              LAT_WAIT  = 200;             // beyond the pipeline depth

  logic clk;
  logic rst_n;

  aar_in_if  in_if ();
  aar_out_if out_if ();

  axis_angle_rotation_matrix DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  out_word_t matrix_q[$];   // matrices still owed by the block
  int        error_cnt = 0;
  bit        idle_on;       // random gaps and stalls allowed
  int        stall_left;

  string entry_name [9] = '{"m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on run length, far above the slowest legal run.
  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Matrix predictor
  // ---------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, bit_w;
    rem   = v;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem  = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  // Q30 product, round half away from zero.
  function automatic longint mul_q30(longint a, longint b);
    longint          p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : p;
    m = (m + (64'd1 << 29)) >> 30;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Q30 to output format, rounded and saturated to 16 bits.
  function automatic logic signed [15:0] scale_out(longint v);
    int              sh;
    longint unsigned m;
    sh = 30 - int'(FRAC_BITS);
    m  = (v < 0) ? longint'(-v) : v;
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) return (m > 32768) ? -16'sd32768 : 16'(-longint'(m));
    return (m > 32767) ? 16'sd32767 : 16'(m);
  endfunction

  function automatic longint unit_part(longint a, longint unsigned len);
    longint unsigned m;
    m = (a < 0) ? longint'(-a) : a;
    m = (m << 46) / len;
    if (m > UNIT_Q30) m = UNIT_Q30;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  // Sine and cosine from octant folding and truncating Taylor series.
  task automatic calc_sin_cos(input logic [15:0] ang, output longint s, output longint c);
    longint unsigned a, frac, r, phi, p2, st, ct;
    longint          sp, cp;
    int unsigned     oct;
    a = ang;
    if (ANGLE_BITS < 32) a &= (64'd1 << ANGLE_BITS) - 1;
    frac = (a << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF;
    oct  = 32'(frac >> 29);
    r    = frac & ((64'd1 << 29) - 1);
    if (oct[0]) r = (64'd1 << 29) - r;
    phi = (r * TURN_STEP + (64'd1 << 31)) >> 32;
    p2  = (phi * phi) >> 30;
    st  = UNIT_Q30;
    ct  = UNIT_Q30;
    for (int i = 0; i < 5; i++) st = UNIT_Q30 - ((p2 * st) >> 30) / SIN_DIV[i];
    for (int i = 0; i < 6; i++) ct = UNIT_Q30 - ((p2 * ct) >> 30) / COS_DIV[i];
    sp = longint'((phi * st) >> 30);
    cp = longint'(ct);
    case (oct)
      0:       begin s = sp;  c = cp;  end
      1:       begin s = cp;  c = sp;  end
      2:       begin s = cp;  c = -sp; end
      3:       begin s = sp;  c = -cp; end
      4:       begin s = -sp; c = -cp; end
      5:       begin s = -cp; c = -sp; end
      6:       begin s = -cp; c = sp;  end
      default: begin s = -sp; c = cp;  end
    endcase
  endtask

  task automatic predict_matrix(input in_word_t w, output out_word_t o);
    longint          ax, ay, az, x, y, z, s, c, t, txy, txz, tyz, sx, sy, sz;
    longint unsigned l2, len;
    ax = w.axis_x;
    ay = w.axis_y;
    az = w.axis_z;
    if (ax == 0 && ay == 0 && az == 0) begin
      // Zero axis: identity whatever the angle, flag raised.
      o.m00 = scale_out(UNIT_Q30);
      o.m11 = scale_out(UNIT_Q30);
      o.m22 = scale_out(UNIT_Q30);
      o.m10 = '0; o.m20 = '0; o.m01 = '0; o.m21 = '0; o.m02 = '0; o.m12 = '0;
      o.zero_axis = 1'b1;
      return;
    end
    l2  = longint'(ax * ax + ay * ay + az * az);
    len = int_sqrt(l2 << 32);
    x   = unit_part(ax, len);
    y   = unit_part(ay, len);
    z   = unit_part(az, len);
    calc_sin_cos(w.angle, s, c);
    t   = longint'(UNIT_Q30) - c;
    txy = mul_q30(t, mul_q30(x, y));
    txz = mul_q30(t, mul_q30(x, z));
    tyz = mul_q30(t, mul_q30(y, z));
    sx  = mul_q30(s, x);
    sy  = mul_q30(s, y);
    sz  = mul_q30(s, z);
    o.m00 = scale_out(mul_q30(t, mul_q30(x, x)) + c);
    o.m10 = scale_out(txy - sz);
    o.m20 = scale_out(txz + sy);
    o.m01 = scale_out(txy + sz);
    o.m11 = scale_out(mul_q30(t, mul_q30(y, y)) + c);
    o.m21 = scale_out(tyz - sx);
    o.m02 = scale_out(txz - sy);
    o.m12 = scale_out(tyz + sx);
    o.m22 = scale_out(mul_q30(t, mul_q30(z, z)) + c);
    o.zero_axis = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Driver: send one word, with an optional random gap before it
  // ---------------------------------------------------------------------

  task automatic send_word(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z, input logic [15:0] ang);
    in_word_t  w;
    out_word_t m;
    int        gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      // Drop valid for a short burst so gaps land on every pipeline phase.
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.axis_x = x;
    w.axis_y = y;
    w.axis_z = z;
    w.angle  = ang;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    // Word taken at this edge: record what the block owes for it.
    predict_matrix(w, m);
    matrix_q.push_back(m);
  endtask

  task automatic drain_matrices();
    // Drop valid so the last word is not sent again while waiting.
    in_if.valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts and field-by-field comparison
  // ---------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t         want, got;
    logic signed [15:0] want_e [9];
    logic signed [15:0] got_e  [9];
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (matrix_q.size() == 0) begin
        $error("unexpected matrix word: m00=%0d zero_axis=%0b", got.m00, got.zero_axis);
        error_cnt++;
      end else begin
        want   = matrix_q.pop_front();
        want_e = '{want.m00, want.m10, want.m20, want.m01, want.m11,
                   want.m21, want.m02, want.m12, want.m22};
        got_e  = '{got.m00, got.m10, got.m20, got.m01, got.m11,
                   got.m21, got.m02, got.m12, got.m22};
        for (int i = 0; i < 9; i++) begin
          if (want_e[i] !== got_e[i]) begin
            $error("%s: expected %0d, actual %0d", entry_name[i], want_e[i], got_e[i]);
            error_cnt++;
          end
        end
        if (want.zero_axis !== got.zero_axis) begin
          $error("zero_axis: expected %0b, actual %0b", want.zero_axis, got.zero_axis);
          error_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Extremes of every field, the zero axis, and each octant boundary.
  task automatic test_directed();
    send_word(16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_word(16'sd0, 16'sd0, 16'sd0, 16'd12345);
    send_word(16'sd0, 16'sd0, 16'sd0, 16'hFFFF);
    send_word(16'sd1, 16'sd0, 16'sd0, 16'd16384);
    send_word(16'sd0, 16'sd1, 16'sd0, 16'd16384);
    send_word(16'sd0, 16'sd0, 16'sd1, 16'd16384);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);
    send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'd32768);
    send_word(-16'sd32768, 16'sd0, 16'sd0, 16'd8192);
    send_word(16'sd32767, -16'sd32768, 16'sd1, 16'd1);
    send_word(-16'sd1, -16'sd1, -16'sd1, 16'd0);
    for (int k = 0; k < 8; k++) begin
      send_word(16'sd3, -16'sd4, 16'sd12, 16'(k * 8192));
    end
    send_word(16'sd5, 16'sd7, -16'sd9, 16'd8191);
    send_word(16'sd5, 16'sd7, -16'sd9, 16'd49153);
  endtask

  // Fully random words: every input bit takes both values.
  task automatic test_random_words(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Short axes hit the zero axis, axis-aligned and exact-length cases often.
  task automatic test_short_axes(input int n);
    logic [15:0] ang;
    for (int i = 0; i < n; i++) begin
      ang = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7) * 8192) : 16'($urandom);
      send_word(16'($signed($urandom_range(0, 8)) - 4), 16'($signed($urandom_range(0, 8)) - 4),
                16'($signed($urandom_range(0, 8)) - 4), ang);
    end
  endtask

  // Hold the sender until every owed matrix is back, then resume.
  task automatic test_pause_until_empty();
    test_random_words(40);
    drain_matrices();
    test_short_axes(20);
  endtask

  initial begin
    int wait_cnt;
    idle_on     = 1'b1;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    // Give reset a clean falling edge before the first clock edge.
    rst_n       = 1'b1;
    #0.5;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_words(900);
    test_pause_until_empty();
    test_short_axes(500);
    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    test_random_words(350);
    in_if.valid <= 1'b0;

    wait_cnt = 0;
    while (matrix_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT_WAIT) @(posedge clk);

    if (error_cnt == 0 && matrix_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (matrix_q.size() != 0) $error("%0d matrices never arrived", matrix_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: axis_angle_rotation_matrix.f
+incdir+hw/rtl
hw/rtl/aar_pkg.sv
hw/rtl/aar_if.sv
hw/rtl/aar_norm.sv
hw/rtl/aar_sincos.sv
hw/rtl/aar_rodrigues.sv
hw/rtl/axis_angle_rotation_matrix.sv
tb/sv/axis_angle_rotation_matrix_tb.sv
